### hw/rtl/kwsc_pkg.sv
package kwsc_pkg;

    localparam int LETTER_W    = 5;
    localparam int FILL_W      = 5;
    localparam int BYTE_W      = 8;
    localparam int MODE_W      = 3;
    localparam int STATUS_W    = 2;
    localparam int ALPHA_COUNT = 26;

    localparam logic [BYTE_W-1:0]   ALPHA_BASE  = 8'd65;
    localparam logic [BYTE_W-1:0]   ALPHA_LAST  = 8'd90;
    localparam logic [BYTE_W-1:0]   LOWER_FIRST = 8'd97;
    localparam logic [BYTE_W-1:0]   LOWER_LAST  = 8'd122;
    localparam logic [BYTE_W-1:0]   CASE_OFFSET = 8'd32;
    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [FILL_W-1:0]   FILL_FULL   = 5'd26;

    localparam logic [MODE_W-1:0] MODE_BEGIN  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_KEY    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FINISH = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ENC    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DEC    = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NOT_READY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED   = 2'd2;

    typedef struct packed {
        logic                we;
        logic [LETTER_W-1:0] addr;
        logic [LETTER_W-1:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic                clear;
        logic                append;
        logic                set_ready;
        logic [LETTER_W-1:0] letter;
    } t_ks_cmd;

    typedef struct packed {
        logic              key_ready;
        logic              appended;
        logic [FILL_W-1:0] fill;
    } t_ks_stat;

endpackage

### hw/rtl/kwsc_if.sv
interface kwsc_in_if;
    import kwsc_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output mode, output in_byte, input ready);
    modport sink   (input valid, input mode, input in_byte, output ready);
endinterface

interface kwsc_out_if;
    import kwsc_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   out_byte;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output out_byte, output status, input ready);
    modport sink   (input valid, input out_byte, input status, output ready);
endinterface

### hw/rtl/keyword_substitution_cipher_core.sv
// Keyword substitution cipher. A begin transaction clears the key, keyword transactions
// append new letters, and a finish transaction fills in the unused letters from Z down
// to A; after that, encrypt and decrypt transactions substitute uppercase letters through
// the key table or its inverse, each held in a 26-entry memory. Every input transaction
// gives one result. Begin, keyword, unused mode codes and pass-through bytes go straight
// to the output register; a substituted byte first takes the registered table read, then
// waits in S_READ while that register is full. Finishing a key that is not yet ready runs
// the sweep, visiting one letter per cycle and writing each unused one into both tables.
// One input transaction is in work at a time; its result waits in an output register and
// the next is taken while that result goes out. No clearing pass is needed after reset.
module keyword_substitution_cipher_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kwsc_in_if.sink     i_in,
    kwsc_out_if.source  o_out
);
    import kwsc_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_WALK = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [LETTER_W-1:0] r_walk;
    logic [LETTER_W-1:0] n_walk;
    logic                r_dec;
    logic                n_dec;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [BYTE_W-1:0]   r_out_byte;
    logic [BYTE_W-1:0]   n_out_byte;
    logic [STATUS_W-1:0] r_out_status;
    logic [STATUS_W-1:0] n_out_status;

    t_ks_cmd  ks_cmd;
    t_ks_stat ks_stat;
    t_mem_wr  key_wr;
    t_mem_wr  inv_wr;

    logic                mem_re;
    logic [LETTER_W-1:0] key_rdata;
    logic [LETTER_W-1:0] inv_rdata;
    logic [LETTER_W-1:0] sel_rdata;

    logic                in_fire;
    logic                out_free;
    logic                load;
    logic                is_upper;
    logic                is_lower;
    logic                kw_ok;
    logic [BYTE_W-1:0]   kw_c;
    logic [BYTE_W-1:0]   kw_idx;
    logic [BYTE_W-1:0]   data_idx;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    assign is_upper = (i_in.in_byte >= ALPHA_BASE) && (i_in.in_byte <= ALPHA_LAST);
    assign is_lower = (i_in.in_byte >= LOWER_FIRST) && (i_in.in_byte <= LOWER_LAST);
    assign kw_c     = is_lower ? (i_in.in_byte - CASE_OFFSET) : i_in.in_byte;
    assign kw_ok    = (kw_c >= ALPHA_BASE) && (kw_c <= ALPHA_LAST);
    assign kw_idx   = kw_c - ALPHA_BASE;
    assign data_idx = i_in.in_byte - ALPHA_BASE;

    assign sel_rdata = r_dec ? inv_rdata : key_rdata;

    always_comb begin
        n_state      = r_state;
        n_walk       = r_walk;
        n_dec        = r_dec;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        load         = 1'b0;
        mem_re       = 1'b0;
        ks_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    unique case (i_in.mode) inside
                        MODE_BEGIN: begin
                            ks_cmd.clear = 1'b1;
                            load         = 1'b1;
                            n_out_byte   = '0;
                            n_out_status = STATUS_OK;
                        end
                        MODE_KEY: begin
                            ks_cmd.append = !ks_stat.key_ready && kw_ok;
                            ks_cmd.letter = kw_idx[LETTER_W-1:0];
                            load          = 1'b1;
                            n_out_byte    = '0;
                            n_out_status  = ks_stat.appended ? STATUS_OK : STATUS_IGNORED;
                        end
                        MODE_FINISH: begin
                            // result is fixed, so it goes out while the sweep runs
                            load         = 1'b1;
                            n_out_byte   = '0;
                            n_out_status = STATUS_OK;
                            if (!ks_stat.key_ready) begin
                                n_state = S_WALK;
                                n_walk  = LAST_LETTER;
                            end
                        end
                        MODE_ENC, MODE_DEC: begin
                            if (!ks_stat.key_ready) begin
                                load         = 1'b1;
                                n_out_byte   = i_in.in_byte;
                                n_out_status = STATUS_NOT_READY;
                            end else if (is_upper) begin
                                mem_re  = 1'b1;
                                n_dec   = (i_in.mode == MODE_DEC);
                                n_state = S_READ;
                            end else begin
                                load         = 1'b1;
                                n_out_byte   = i_in.in_byte;
                                n_out_status = STATUS_OK;
                            end
                        end
                        default: begin
                            load         = 1'b1;
                            n_out_byte   = '0;
                            n_out_status = STATUS_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                // table data holds while the output register is still full
                if (out_free) begin
                    load         = 1'b1;
                    n_out_byte   = ALPHA_BASE + {{(BYTE_W-LETTER_W){1'b0}}, sel_rdata};
                    n_out_status = STATUS_OK;
                    n_state      = S_IDLE;
                end
            end
            S_WALK: begin
                ks_cmd.append = 1'b1;
                ks_cmd.letter = r_walk;
                if (r_walk == '0) begin
                    ks_cmd.set_ready = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_walk = r_walk - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_out_valid = 1'b1;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_walk       <= n_walk;
        r_dec        <= n_dec;
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
    end

    kwsc_keystate u_keystate (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (ks_cmd),
        .o_stat   (ks_stat),
        .o_key_wr (key_wr),
        .o_inv_wr (inv_wr)
    );

    // writes and reads never overlap: a read only starts from idle
    kwsc_mem u_key_mem (
        .i_clk   (i_clk),
        .i_wr    (key_wr),
        .i_re    (mem_re),
        .i_raddr (data_idx[LETTER_W-1:0]),
        .o_rdata (key_rdata)
    );

    kwsc_mem u_inv_mem (
        .i_clk   (i_clk),
        .i_wr    (inv_wr),
        .i_re    (mem_re),
        .i_raddr (data_idx[LETTER_W-1:0]),
        .o_rdata (inv_rdata)
    );

    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.status   = r_out_status;

    a_walk_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> !ks_stat.key_ready)
        else $error("letter sweep running on a ready key");

    a_read_needs_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> ks_stat.key_ready)
        else $error("table read without a complete key");

    a_walk_fills_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK && r_walk == '0) |=> (ks_stat.fill == FILL_FULL && ks_stat.key_ready))
        else $error("letter sweep ended with an incomplete key");
endmodule

### hw/rtl/kwsc_mem.sv
module kwsc_mem (
    input  logic                              i_clk,
    input  kwsc_pkg::t_mem_wr                 i_wr,
    input  logic                              i_re,
    input  logic [kwsc_pkg::LETTER_W-1:0]     i_raddr,
    output logic [kwsc_pkg::LETTER_W-1:0]     o_rdata
);
    import kwsc_pkg::*;

    logic [LETTER_W-1:0] r_mem [ALPHA_COUNT];
    logic [LETTER_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        // read data holds until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/kwsc_keystate.sv
module kwsc_keystate (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  kwsc_pkg::t_ks_cmd  i_cmd,
    output kwsc_pkg::t_ks_stat o_stat,
    output kwsc_pkg::t_mem_wr  o_key_wr,
    output kwsc_pkg::t_mem_wr  o_inv_wr
);
    import kwsc_pkg::*;

    logic [ALPHA_COUNT-1:0] r_used;
    logic [ALPHA_COUNT-1:0] n_used;
    logic [FILL_W-1:0]      r_fill;
    logic [FILL_W-1:0]      n_fill;
    logic                   r_key_ready;
    logic                   n_key_ready;
    logic                   appended;

    assign appended = i_cmd.append && !r_used[i_cmd.letter] && (r_fill < FILL_FULL);

    always_comb begin
        n_used      = r_used;
        n_fill      = r_fill;
        n_key_ready = r_key_ready;
        if (i_cmd.clear) begin
            n_used      = '0;
            n_fill      = '0;
            n_key_ready = 1'b0;
        end else begin
            if (appended) begin
                n_used[i_cmd.letter] = 1'b1;
                n_fill               = r_fill + 1'b1;
            end
            if (i_cmd.set_ready) begin
                n_key_ready = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_fill      <= '0;
            r_key_ready <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_fill      <= n_fill;
            r_key_ready <= n_key_ready;
        end
    end

    // key table indexed by position, inverse table indexed by letter
    assign o_key_wr.we   = appended;
    assign o_key_wr.addr = r_fill;
    assign o_key_wr.data = i_cmd.letter;
    assign o_inv_wr.we   = appended;
    assign o_inv_wr.addr = i_cmd.letter;
    assign o_inv_wr.data = r_fill;

    assign o_stat.key_ready = r_key_ready;
    assign o_stat.appended  = appended;
    assign o_stat.fill      = r_fill;
endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
    import kwsc_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int IDLE_PCT     = 49;
    localparam int BOTH_PCT     = 29;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 40;
    localparam int TIMEOUT_NS   = 2_000_000;

    localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [BYTE_W-1:0]   out_byte;
        logic [STATUS_W-1:0] status;
    } t_cipher_result;

    typedef struct packed {
        logic [MODE_W-1:0]   mode;
        logic [BYTE_W-1:0]   data;
        logic                fixed;
        logic [BYTE_W-1:0]   exp_byte;
        logic [STATUS_W-1:0] exp_status;
    } t_directed_txn;

    localparam int NUM_DIRECTED = 29;

    // fixed rows carry their own expectation, the rest go through the predictor
    t_directed_txn directed_txns [NUM_DIRECTED] = '{
        '{MODE_ENC,      "A",   1'b1, "A",   STATUS_NOT_READY},
        '{MODE_DEC,      8'hFF, 1'b1, 8'hFF, STATUS_NOT_READY},
        '{MODE_SPARE_LO, 8'hFF, 1'b1, 8'h00, STATUS_OK},
        '{MODE_SPARE_HI, 8'h00, 1'b1, 8'h00, STATUS_OK},
        '{MODE_BEGIN,    8'h55, 1'b1, 8'h00, STATUS_OK},
        '{MODE_KEY,      "z",   1'b1, 8'h00, STATUS_OK},
        '{MODE_KEY,      "Z",   1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_KEY,      "1",   1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_KEY,      8'h00, 1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_KEY,      8'hFF, 1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_KEY,      "a",   1'b1, 8'h00, STATUS_OK},
        '{MODE_KEY,      "@",   1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_KEY,      "{",   1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_ENC,      "Q",   1'b1, "Q",   STATUS_NOT_READY},
        '{MODE_FINISH,   8'hAA, 1'b1, 8'h00, STATUS_OK},
        '{MODE_FINISH,   8'h00, 1'b1, 8'h00, STATUS_OK},
        '{MODE_KEY,      "B",   1'b1, 8'h00, STATUS_IGNORED},
        '{MODE_ENC,      "A",   1'b0, 8'h00, STATUS_OK},
        '{MODE_ENC,      "Z",   1'b0, 8'h00, STATUS_OK},
        '{MODE_DEC,      "A",   1'b0, 8'h00, STATUS_OK},
        '{MODE_ENC,      "a",   1'b1, "a",   STATUS_OK},
        '{MODE_DEC,      "@",   1'b1, "@",   STATUS_OK},
        '{MODE_ENC,      "[",   1'b1, "[",   STATUS_OK},
        '{MODE_ENC,      8'hFF, 1'b1, 8'hFF, STATUS_OK},
        '{MODE_DEC,      8'h00, 1'b1, 8'h00, STATUS_OK},
        '{MODE_BEGIN,    8'hFF, 1'b1, 8'h00, STATUS_OK},
        '{MODE_FINISH,   8'h00, 1'b1, 8'h00, STATUS_OK},
        '{MODE_ENC,      "A",   1'b0, 8'h00, STATUS_OK},
        '{MODE_DEC,      "M",   1'b0, 8'h00, STATUS_OK}
    };

    logic i_clk;
    logic i_rst_n;

    kwsc_in_if  in_ch ();
    kwsc_out_if out_ch ();

    keyword_substitution_cipher_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // predictor state
    logic [LETTER_W-1:0] key_map [ALPHA_COUNT];
    logic [LETTER_W-1:0] inv_map [ALPHA_COUNT];
    logic [ALPHA_COUNT-1:0] letters_used = '0;
    logic [FILL_W-1:0]      key_len      = '0;
    logic                   key_done     = 1'b0;

    t_cipher_result expected_results [$];

    // expectation riding along with the transaction being offered
    logic                fixed_valid  = 1'b0;
    logic [BYTE_W-1:0]   fixed_byte   = '0;
    logic [STATUS_W-1:0] fixed_status = '0;

    int n_errors   = 0;
    int items_sent = 0;
    int idle_pct   = 0;
    int stall_pct  = 0;

    function automatic bit add_key_letter(input logic [LETTER_W-1:0] letter);
        if (key_len >= FILL_FULL || letters_used[letter]) return 1'b0;
        key_map[key_len] = letter;
        inv_map[letter]  = key_len;
        letters_used[letter] = 1'b1;
        key_len = key_len + 1'b1;
        return 1'b1;
    endfunction

    function automatic t_cipher_result cipher_predict(input logic [MODE_W-1:0] mode,
                                                      input logic [BYTE_W-1:0] data);
        t_cipher_result r;
        logic [BYTE_W-1:0]   c;
        logic [LETTER_W-1:0] v;
        r.out_byte = '0;
        r.status   = STATUS_OK;
        case (mode)
            MODE_BEGIN: begin
                letters_used = '0;
                key_len      = '0;
                key_done     = 1'b0;
            end
            MODE_KEY: begin
                c = data;
                if (c >= LOWER_FIRST && c <= LOWER_LAST) c = c - CASE_OFFSET;
                if (key_done || c < ALPHA_BASE || c > ALPHA_LAST ||
                    !add_key_letter(LETTER_W'(c - ALPHA_BASE)))
                    r.status = STATUS_IGNORED;
            end
            MODE_FINISH: begin
                if (!key_done) begin
                    for (int k = ALPHA_COUNT - 1; k >= 0; k--)
                        void'(add_key_letter(LETTER_W'(k)));
                    key_done = 1'b1;
                end
            end
            MODE_ENC, MODE_DEC: begin
                r.out_byte = data;
                if (!key_done) begin
                    r.status = STATUS_NOT_READY;
                end else if (data >= ALPHA_BASE && data <= ALPHA_LAST) begin
                    v = (mode == MODE_ENC) ? key_map[LETTER_W'(data - ALPHA_BASE)]
                                           : inv_map[LETTER_W'(data - ALPHA_BASE)];
                    r.out_byte = ALPHA_BASE + BYTE_W'(v);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [BYTE_W-1:0] got,
                                   input logic [BYTE_W-1:0] want);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    endtask

    task automatic send_txn(input logic [MODE_W-1:0] mode, input logic [BYTE_W-1:0] data,
                            input logic fx = 1'b0, input logic [BYTE_W-1:0] eb = '0,
                            input logic [STATUS_W-1:0] es = '0);
        while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.mode    <= mode;
        in_ch.in_byte <= data;
        fixed_valid   <= fx;
        fixed_byte    <= eb;
        fixed_status  <= es;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (mode <= MODE_DEC) items_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_letter(input bit lower);
        return (lower ? LOWER_FIRST : ALPHA_BASE) + BYTE_W'($urandom_range(ALPHA_COUNT - 1));
    endfunction

    // begin, keyword bytes, mostly a finish, then a run of data bytes, with some misuse mixed in
    task automatic run_key_session();
        int n_key;
        int n_data;
        logic [BYTE_W-1:0] b;
        logic [MODE_W-1:0] m;
        send_txn(MODE_BEGIN, BYTE_W'($urandom));
        n_key = ($urandom_range(3) == 0) ? $urandom_range(26, 45) : $urandom_range(0, 8);
        for (int i = 0; i < n_key; i++) begin
            case ($urandom_range(9))
                0, 1:    b = BYTE_W'($urandom);
                2, 3, 4: b = pick_letter(1'b1);
                default: b = pick_letter(1'b0);
            endcase
            send_txn(MODE_KEY, b);
        end
        if ($urandom_range(7) != 0) send_txn(MODE_FINISH, BYTE_W'($urandom));
        if ($urandom_range(5) == 0)
            send_txn($urandom_range(1) ? MODE_FINISH : MODE_KEY, pick_letter($urandom_range(1)));
        n_data = $urandom_range(4, 24);
        for (int i = 0; i < n_data; i++) begin
            m = $urandom_range(1) ? MODE_ENC : MODE_DEC;
            case ($urandom_range(11))
                0: begin
                    m = MODE_W'($urandom_range(7));
                    b = BYTE_W'($urandom);
                end
                1, 2: b = BYTE_W'($urandom);
                3:    b = pick_letter(1'b1);
                default: b = pick_letter(1'b0);
            endcase
            send_txn(m, b);
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            out_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    // scoreboard: predict on each accepted input, check each accepted result
    initial begin : monitor
        t_cipher_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (in_ch.valid && in_ch.ready) begin
                    want = cipher_predict(in_ch.mode, in_ch.in_byte);
                    if (fixed_valid) want = '{fixed_byte, fixed_status};
                    expected_results.push_back(want);
                end
                if (out_ch.valid && out_ch.ready) begin
                    if (expected_results.size() == 0) begin
                        report_mismatch("unexpected result, out_byte", out_ch.out_byte, '0);
                    end else begin
                        want = expected_results.pop_front();
                        if (out_ch.out_byte !== want.out_byte)
                            report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
                        if (out_ch.status !== want.status)
                            report_mismatch("status", BYTE_W'(out_ch.status),
                                            BYTE_W'(want.status));
                    end
                end
            end
        end
    end

    initial begin : stimulus
        int rand_base;
        int phase;
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.mode    <= MODE_BEGIN;
        in_ch.in_byte <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_txns[i])
            send_txn(directed_txns[i].mode, directed_txns[i].data, directed_txns[i].fixed,
                     directed_txns[i].exp_byte, directed_txns[i].exp_status);

        rand_base = items_sent;
        while (items_sent - rand_base < RANDOM_ITEMS) begin
            phase = (items_sent - rand_base) * 4 / RANDOM_ITEMS;
            case (phase)
                0:       begin idle_pct = 0;        stall_pct = 0;        end
                1:       begin idle_pct = IDLE_PCT; stall_pct = 0;        end
                2:       begin idle_pct = 0;        stall_pct = IDLE_PCT; end
                default: begin idle_pct = BOTH_PCT; stall_pct = BOTH_PCT; end
            endcase
            run_key_session();
        end
        in_ch.valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        // a late finish sweep can still be running
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
